@@ sv/aabb_pkg.sv @@
package aabb_pkg;

    // Wide working width for exact edge sums and shifted products.
    localparam int WIDE_W = 64;
    // Operand width of the shared multiplier.
    localparam int OPW = 34;

    localparam int DEF_MAX_STATIC_BOXES = 64;
    localparam int DEF_FRACTION_BITS    = 16;

    // Reset values of the configuration registers.
    localparam logic [16:0]        RST_TIME_STEP    = 17'd1092;
    localparam logic signed [31:0] RST_GRAVITY_Y    = 32'sd642908;
    localparam logic [30:0]        RST_SLOP         = 31'd655;
    localparam logic [16:0]        RST_CORR_GAIN    = 17'd52429;
    localparam logic [6:0]         RST_STATIC_COUNT = 7'd0;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP    = 3'd0,
        CFG_GRAVITY_Y    = 3'd1,
        CFG_SLOP         = 3'd2,
        CFG_CORR_GAIN    = 3'd3,
        CFG_STATIC_COUNT = 3'd4
    } t_cfg_idx;

    // Input function codes.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [OPW-1:0]    t_opnd;

    typedef struct packed {
        logic signed [31:0] left;
        logic signed [31:0] top;
        logic [30:0]        w;
        logic [30:0]        h;
    } t_box;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GRAV,
        ST_DRAG,
        ST_FACT,
        ST_VX,
        ST_VY,
        ST_PX,
        ST_PY,
        ST_PYW,
        ST_RD,
        ST_EDGE,
        ST_OV,
        ST_NRM,
        ST_CORR,
        ST_APPLY,
        ST_REFL
    } t_state;

    // Clamp a wide value into 32-bit signed range.
    function automatic logic signed [31:0] sat32(input t_wide v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

@@ sv/aabb_mul.sv @@
module aabb_mul #(
    parameter int FRACTION_BITS = aabb_pkg::DEF_FRACTION_BITS
) (
    input  logic            i_clk,
    input  aabb_pkg::t_opnd i_a,
    input  aabb_pkg::t_opnd i_b,
    output aabb_pkg::t_wide o_p
);
    import aabb_pkg::*;

    logic signed [2*OPW-1:0] w_prod;
    logic signed [2*OPW-1:0] w_shift;
    t_wide                   r_p;

    // Full signed product; the arithmetic shift rounds toward minus infinity.
    assign w_prod  = i_a * i_b;
    assign w_shift = w_prod >>> FRACTION_BITS;

    // Registered result, consumed by the sequencer in the next cycle.
    always_ff @(posedge i_clk) begin
        r_p <= w_shift[WIDE_W-1:0];
    end

    assign o_p = r_p;

endmodule

@@ sv/aabb_box_mem.sv @@
module aabb_box_mem #(
    parameter int DEPTH = aabb_pkg::DEF_MAX_STATIC_BOXES,
    parameter int AW    = 6
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  aabb_pkg::t_box i_wdata,
    input  logic [AW-1:0]  i_raddr,
    output aabb_pkg::t_box o_rdata
);
    import aabb_pkg::*;

    t_box r_mem [DEPTH];
    t_box r_rdata;

    // One write port for load beats.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // One registered read port for the collision walk.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/aabb_body_step_and_collide_core.sv @@
// Steps one moving box per step beat and resolves it against a table of static boxes.
// A load beat (func 0) writes one table entry and gives no result.
// A step beat (func 1) integrates on the shared multiplier (gravity, drag, factor,
// velocity, position), then walks the static boxes: read, edges, overlap and normal for
// each box, plus correction, apply and, if the body moves into it, reflection for a box
// that is hit; the result then goes to the output register once that is free. The walk
// covers static_count boxes (limited to the table depth); the shared multiplier and the
// one table read port set this order. The input is stalled while a step is in progress,
// and one finished result waits in the output register while the next beat is taken.
module aabb_body_step_and_collide_core #(
    parameter int MAX_STATIC_BOXES = aabb_pkg::DEF_MAX_STATIC_BOXES,
    parameter int FRACTION_BITS    = aabb_pkg::DEF_FRACTION_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [aabb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    // Input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_func,
    input  logic [5:0]                     i_box_index,
    input  logic signed [31:0]             i_pos_x,
    input  logic signed [31:0]             i_pos_y,
    input  logic [30:0]                    i_size_w,
    input  logic [30:0]                    i_size_h,
    input  logic signed [31:0]             i_vel_x,
    input  logic signed [31:0]             i_vel_y,
    input  logic                           i_use_gravity,
    input  logic [16:0]                    i_drag,
    input  logic [16:0]                    i_restitution,
    // Output channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [31:0]             o_new_pos_x,
    output logic signed [31:0]             o_new_pos_y,
    output logic signed [31:0]             o_new_vel_x,
    output logic signed [31:0]             o_new_vel_y,
    output logic                           o_hit,
    output logic [5:0]                     o_hit_index,
    output logic signed [1:0]              o_normal_x,
    output logic signed [1:0]              o_normal_y,
    output logic [30:0]                    o_hit_depth
);
    import aabb_pkg::*;

    localparam int AW   = (MAX_STATIC_BOXES > 1) ? $clog2(MAX_STATIC_BOXES) : 1;
    localparam int CNTW = (AW + 1 > 7) ? AW + 1 : 7;
    localparam t_wide ONE = t_wide'(1) <<< FRACTION_BITS;

    // Configuration registers
    logic [16:0]        r_time_step;
    logic signed [31:0] r_gravity_y;
    logic [30:0]        r_slop;
    logic [16:0]        r_corr_gain;
    logic [6:0]         r_static_count;

    // Sequencer and body state
    t_state             r_state, n_state;
    logic signed [31:0] r_px, r_py, r_vx, r_vy, r_f;
    logic [30:0]        r_w, r_h;
    logic [16:0]        r_drag, r_rest;
    logic               r_grav;
    logic [CNTW-1:0]    r_idx;

    // Per-box working registers
    t_wide              r_ar, r_br, r_ab, r_bb, r_bl, r_bt, r_ox, r_oy, r_cpre;
    logic               r_cxlt, r_cylt, r_axx, r_neg;

    // Last hit
    logic               r_hit;
    logic [5:0]         r_hidx;
    logic signed [1:0]  r_nx, r_ny;
    logic [30:0]        r_hdepth;

    // Output register
    logic               r_ov;
    logic signed [31:0] r_o_px, r_o_py, r_o_vx, r_o_vy;
    logic               r_o_hit;
    logic [5:0]         r_o_hidx;
    logic signed [1:0]  r_o_nx, r_o_ny;
    logic [30:0]        r_o_depth;

    logic               w_in_acc, w_load, w_out_free;
    logic [CNTW-1:0]    w_ld_idx, w_cnt, w_max, w_nbox;
    t_box               w_wdata, w_rd;
    t_opnd              w_mul_a, w_mul_b;
    t_wide              w_p;
    t_wide              w_ox, w_oy, w_depth, w_cdiff, w_corr;
    logic               w_overlap;
    logic signed [31:0] w_pos, w_vel, w_newpos;
    logic               w_refl;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != ST_IDLE);
    assign w_in_acc    = i_valid && !o_stall;
    assign w_out_free  = !r_ov || !i_stall;

    // Load beats write the table; entries beyond the table are dropped.
    assign w_ld_idx = CNTW'(i_box_index);
    assign w_max    = CNTW'(MAX_STATIC_BOXES);
    assign w_load   = w_in_acc && (i_func == FUNC_LOAD) && (w_ld_idx < w_max);
    assign w_wdata  = '{left: i_pos_x, top: i_pos_y, w: i_size_w, h: i_size_h};

    // Number of boxes walked, limited to the table depth.
    assign w_cnt  = CNTW'(r_static_count);
    assign w_nbox = (w_cnt > w_max) ? w_max : w_cnt;

    aabb_box_mem #(
        .DEPTH (MAX_STATIC_BOXES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (w_ld_idx[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rd)
    );

    aabb_mul #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_p)
    );

    // Overlap, depth and correction terms for the box under test.
    assign w_ox      = ((r_ar < r_br) ? r_ar : r_br) - ((t_wide'(r_px) > r_bl) ? t_wide'(r_px) : r_bl);
    assign w_oy      = ((r_ab < r_bb) ? r_ab : r_bb) - ((t_wide'(r_py) > r_bt) ? t_wide'(r_py) : r_bt);
    assign w_overlap = (r_ox > 0) && (r_oy > 0);
    assign w_depth   = (r_ox < r_oy) ? r_ox : r_oy;
    assign w_cdiff   = w_depth - t_wide'(r_slop);

    // Push along the normal and check whether the body moves into the box.
    assign w_pos    = r_axx ? r_px : r_py;
    assign w_vel    = r_axx ? r_vx : r_vy;
    assign w_corr   = r_neg ? -w_p : w_p;
    assign w_newpos = sat32(t_wide'(w_pos) + w_corr);
    assign w_refl   = r_neg ? (w_vel > 0) : (w_vel < 0);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and multiplier operand selection
    always_comb begin
        n_state = r_state;
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_func == FUNC_STEP)) begin
                    n_state = ST_GRAV;
                end
            end
            ST_GRAV: begin
                w_mul_a = t_opnd'(r_gravity_y);
                w_mul_b = t_opnd'(r_time_step);
                n_state = ST_DRAG;
            end
            ST_DRAG: begin
                w_mul_a = t_opnd'(r_drag);
                w_mul_b = t_opnd'(r_time_step);
                n_state = ST_FACT;
            end
            ST_FACT: n_state = ST_VX;
            ST_VX: begin
                w_mul_a = t_opnd'(r_vx);
                w_mul_b = t_opnd'(r_f);
                n_state = ST_VY;
            end
            ST_VY: begin
                w_mul_a = t_opnd'(r_vy);
                w_mul_b = t_opnd'(r_f);
                n_state = ST_PX;
            end
            ST_PX: begin
                w_mul_a = t_opnd'(r_vx);
                w_mul_b = t_opnd'(r_time_step);
                n_state = ST_PY;
            end
            ST_PY: begin
                w_mul_a = t_opnd'(r_vy);
                w_mul_b = t_opnd'(r_time_step);
                n_state = ST_PYW;
            end
            ST_PYW: n_state = ST_RD;
            ST_RD: begin
                if (r_idx >= w_nbox) begin
                    if (w_out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_EDGE;
                end
            end
            ST_EDGE: n_state = ST_OV;
            ST_OV:   n_state = ST_NRM;
            ST_NRM:  n_state = w_overlap ? ST_CORR : ST_RD;
            ST_CORR: begin
                w_mul_a = t_opnd'(r_cpre);
                w_mul_b = t_opnd'(r_corr_gain);
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                w_mul_a = t_opnd'(w_vel);
                w_mul_b = t_opnd'(ONE + t_wide'(r_rest));
                n_state = w_refl ? ST_REFL : ST_RD;
            end
            ST_REFL: n_state = ST_RD;
            default: n_state = ST_IDLE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step    <= RST_TIME_STEP;
            r_gravity_y    <= RST_GRAVITY_Y;
            r_slop         <= RST_SLOP;
            r_corr_gain    <= RST_CORR_GAIN;
            r_static_count <= RST_STATIC_COUNT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TIME_STEP:    r_time_step    <= i_cfg_data[16:0];
                CFG_GRAVITY_Y:    r_gravity_y    <= i_cfg_data;
                CFG_SLOP:         r_slop         <= i_cfg_data[30:0];
                CFG_CORR_GAIN:    r_corr_gain    <= i_cfg_data[16:0];
                CFG_STATIC_COUNT: r_static_count <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Body datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    r_px   <= i_pos_x;
                    r_py   <= i_pos_y;
                    r_w    <= i_size_w;
                    r_h    <= i_size_h;
                    r_vx   <= i_vel_x;
                    r_vy   <= i_vel_y;
                    r_grav <= i_use_gravity;
                    r_drag <= i_drag;
                    r_rest <= i_restitution;
                end
            end
            ST_DRAG: begin
                if (r_grav) begin
                    r_vy <= sat32(t_wide'(r_vy) + w_p);
                end
            end
            ST_FACT:  r_f  <= sat32(ONE - w_p);
            ST_VY:    r_vx <= sat32(w_p);
            ST_PX:    r_vy <= sat32(w_p);
            ST_PY:    r_px <= sat32(t_wide'(r_px) + w_p);
            ST_PYW:   r_py <= sat32(t_wide'(r_py) + w_p);
            ST_EDGE: begin
                r_ar   <= t_wide'(r_px) + t_wide'(r_w);
                r_ab   <= t_wide'(r_py) + t_wide'(r_h);
                r_br   <= t_wide'(w_rd.left) + t_wide'(w_rd.w);
                r_bb   <= t_wide'(w_rd.top) + t_wide'(w_rd.h);
                r_bl   <= t_wide'(w_rd.left);
                r_bt   <= t_wide'(w_rd.top);
                r_cxlt <= ((t_wide'(r_px) <<< 1) + t_wide'(r_w))
                        < ((t_wide'(w_rd.left) <<< 1) + t_wide'(w_rd.w));
                r_cylt <= ((t_wide'(r_py) <<< 1) + t_wide'(r_h))
                        < ((t_wide'(w_rd.top) <<< 1) + t_wide'(w_rd.h));
            end
            ST_OV: begin
                r_ox <= w_ox;
                r_oy <= w_oy;
            end
            ST_NRM: begin
                r_axx  <= (r_ox < r_oy);
                r_neg  <= (r_ox < r_oy) ? r_cxlt : r_cylt;
                r_cpre <= (w_cdiff < 0) ? t_wide'(0) : w_cdiff;
            end
            ST_APPLY: begin
                if (r_axx) begin
                    r_px <= w_newpos;
                end else begin
                    r_py <= w_newpos;
                end
            end
            ST_REFL: begin
                if (r_axx) begin
                    r_vx <= sat32(t_wide'(r_vx) - w_p);
                end else begin
                    r_vy <= sat32(t_wide'(r_vy) - w_p);
                end
            end
            default: ;
        endcase
    end

    // Box walk counter and last-hit record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_hidx   <= '0;
            r_nx     <= '0;
            r_ny     <= '0;
            r_hdepth <= '0;
        end else begin
            if (r_state == ST_IDLE && w_in_acc) begin
                r_idx    <= '0;
                r_hit    <= 1'b0;
                r_hidx   <= '0;
                r_nx     <= '0;
                r_ny     <= '0;
                r_hdepth <= '0;
            end
            if ((r_state == ST_NRM && !w_overlap) || (r_state == ST_APPLY && !w_refl)
                    || r_state == ST_REFL) begin
                r_idx <= r_idx + CNTW'(1);
            end
            if (r_state == ST_NRM && w_overlap) begin
                r_hit    <= 1'b1;
                r_hidx   <= r_idx[5:0];
                r_hdepth <= w_depth[30:0];
                if (r_ox < r_oy) begin
                    r_nx <= r_cxlt ? -2'sd1 : 2'sd1;
                    r_ny <= 2'sd0;
                end else begin
                    r_nx <= 2'sd0;
                    r_ny <= r_cylt ? -2'sd1 : 2'sd1;
                end
            end
        end
    end

    // Output register: filled at the end of the walk, freed when the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == ST_RD && r_idx >= w_nbox && w_out_free) begin
            r_ov <= 1'b1;
        end else if (r_ov && !i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD && r_idx >= w_nbox && w_out_free) begin
            r_o_px    <= r_px;
            r_o_py    <= r_py;
            r_o_vx    <= r_vx;
            r_o_vy    <= r_vy;
            r_o_hit   <= r_hit;
            r_o_hidx  <= r_hidx;
            r_o_nx    <= r_nx;
            r_o_ny    <= r_ny;
            r_o_depth <= r_hdepth;
        end
    end

    assign o_valid     = r_ov;
    assign o_new_pos_x = r_o_px;
    assign o_new_pos_y = r_o_py;
    assign o_new_vel_x = r_o_vx;
    assign o_new_vel_y = r_o_vy;
    assign o_hit       = r_o_hit;
    assign o_hit_index = r_o_hidx;
    assign o_normal_x  = r_o_nx;
    assign o_normal_y  = r_o_ny;
    assign o_hit_depth = r_o_depth;

`ifndef SYNTH
    // A recorded hit has exactly one nonzero normal component.
    a_hit_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> ((r_nx == 2'sd0) != (r_ny == 2'sd0)))
        else $error("hit record without a single-axis normal");

    // Without a hit, the hit fields stay cleared.
    a_nohit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_hit |-> (r_nx == 2'sd0 && r_ny == 2'sd0 && r_hdepth == '0 && r_hidx == '0))
        else $error("hit fields set without a hit");

    // A load beat never starts the sequencer.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_valid && !o_stall && i_func == FUNC_LOAD)
        |=> r_state == ST_IDLE)
        else $error("load beat left the idle state");

    // The walk ends only through the table read state.
    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) != ST_IDLE && r_state == ST_IDLE) |-> $past(r_state) == ST_RD)
        else $error("step finished outside the table read state");
`endif

endmodule
